// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ----- rtl/jccal_pkg.sv -----
// ----------------------------------------------------------------------------
// Joystick calibrator package
// Phase codes, register indexes, register reset values and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jccal_pkg;

   // Calibration phases, in the order they are normally visited.
   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_CENTER = 3'd1,
      PH_SWEEP  = 3'd2,
      PH_READY  = 3'd3,
      PH_IDLE   = 3'd4,
      PH_EXIT   = 3'd5
   } phase_type;

   localparam int CSR_IDX_W = 2;
   localparam int CFG_W     = 10;
   localparam int TICK_W    = 11;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE_TICKS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_TICKS  = 2'd2;

   // Register reset values.
   localparam logic [CFG_W-1:0] PAUSE_TICKS_RST  = 10'd60;
   localparam logic [CFG_W-1:0] CENTER_TICKS_RST = 10'd200;
   localparam logic [CFG_W-1:0] SWEEP_TICKS_RST  = 10'd400;

   // Window decision for a center or sweep tick.
   typedef enum logic [1:0] {
      WIN_COUNT  = 2'd0,
      WIN_SAMPLE = 2'd1,
      WIN_DONE   = 2'd2
   } window_type;

   // Current register values.
   typedef struct packed {
      logic [CFG_W-1:0] pause_ticks;
      logic [CFG_W-1:0] center_ticks;
      logic [CFG_W-1:0] sweep_ticks;
   } cfg_type;

   // Per-axis controls from the phase sequencer.
   typedef struct packed {
      logic load;     // commit this request's state update
      logic restart;  // start from reset values
      logic avg;      // fold the sample into the center average
      logic track;    // track min and max against the center
   } axis_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/joystick_center_range_calibrator_unit.sv -----
// ----------------------------------------------------------------------------
// Joystick center and range calibrator
// Steps a two-axis joystick through center averaging and range sweep phases.
// ----------------------------------------------------------------------------
// Each request is one tick carrying an X/Y sample plus abort and restart flags,
// and yields exactly one response with the phase, the averaged center and the
// min/max range after that tick. The block takes one request per clock
// sustained while responses are accepted; a response is presented from the
// result register after its request passes the input register, and a stalled
// response holds while the next request waits in the input register.
// The rate is set by the update of the phase, tick count and axis registers,
// which each request reads and writes. Register writes (pause, center and
// sweep lengths) take effect on the following request and should be made
// while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module joystick_center_range_calibrator_unit #(
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request channel.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // tdata: sample_x, sample_y, zero fill.
   input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  req_tdata,
   // tuser: abort, restart.
   input  wire logic [1:0]                          req_tuser,
   // Response channel.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // tdata: phase, center_x, center_y, min_x, max_x, min_y, max_y, zero fill.
   output logic [((3+6*SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,
   // tuser: finished.
   output logic [0:0]                               rsp_tuser,
   // Configuration write channel.
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [jccal_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [jccal_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int SB = SAMPLE_BITS;
   localparam int RSP_W = ((3 + 6 * SB + 7) / 8) * 8;
   localparam int RSP_USED = 3 + 6 * SB;

   jccal_pkg::cfg_type   cfg;
   jccal_pkg::phase_type phase;
   logic [SB-1:0]        center_x;
   logic [SB-1:0]        center_y;
   logic [SB-1:0]        min_x;
   logic [SB-1:0]        max_x;
   logic [SB-1:0]        min_y;
   logic [SB-1:0]        max_y;
   logic                 finished;
   logic [RSP_USED-1:0]  rsp_packed;

   jccal_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   jccal_core #(.SAMPLE_BITS(SB)) u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_sample_x  (req_tdata[SB-1:0]),
      .in_sample_y  (req_tdata[2*SB-1:SB]),
      .in_abort     (req_tuser[0]),
      .in_restart   (req_tuser[1]),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_phase    (phase),
      .out_center_x (center_x),
      .out_center_y (center_y),
      .out_min_x    (min_x),
      .out_max_x    (max_x),
      .out_min_y    (min_y),
      .out_max_y    (max_y),
      .out_finished (finished)
   );

   // Pack the response fields, first field in the lowest bits.
   assign rsp_packed   = {max_y, min_y, max_x, min_x, center_y, center_x, phase};
   assign rsp_tdata    = RSP_W'(rsp_packed);
   assign rsp_tuser[0] = finished;

endmodule

`default_nettype wire

// ----- rtl/jccal_csr.sv -----
// ----------------------------------------------------------------------------
// Joystick calibrator register file
// Holds the three window length registers written through the config port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jccal_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [jccal_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [jccal_pkg::CFG_W-1:0]        csr_wdata,
   output jccal_pkg::cfg_type                      cfg
);

   jccal_pkg::cfg_type cfg_ff;
   jccal_pkg::cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Address decode; an index beyond the list is dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            jccal_pkg::CSR_PAUSE_TICKS:  cfg_in.pause_ticks  = csr_wdata;
            jccal_pkg::CSR_CENTER_TICKS: cfg_in.center_ticks = csr_wdata;
            jccal_pkg::CSR_SWEEP_TICKS:  cfg_in.sweep_ticks  = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pause_ticks  <= jccal_pkg::PAUSE_TICKS_RST;
         cfg_ff.center_ticks <= jccal_pkg::CENTER_TICKS_RST;
         cfg_ff.sweep_ticks  <= jccal_pkg::SWEEP_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/jccal_axis.sv -----
// ----------------------------------------------------------------------------
// Joystick calibrator axis datapath
// Center average and min/max tracking for one axis, with its state registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jccal_axis #(
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire jccal_pkg::axis_ctl_type     ctl,
   input  wire logic [SAMPLE_BITS-1:0]      sample,
   output logic      [SAMPLE_BITS-1:0]      center_in,
   output logic      [SAMPLE_BITS-1:0]      min_in,
   output logic      [SAMPLE_BITS-1:0]      max_in
);

   // Width of 7*center + 3*sample, which stays below 16 * 2^SAMPLE_BITS.
   localparam int SUM_W = SAMPLE_BITS + 4;
   // Reciprocal of ten scaled by 2^SHIFT; the product underestimates by at most one.
   localparam int SHIFT = SUM_W + 4;
   localparam int RECIP_W = SHIFT - 3;
   localparam int PROD_W = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SHIFT) / 10);
   localparam logic [SUM_W-1:0] TEN = SUM_W'(10);
   localparam logic [SAMPLE_BITS-1:0] MID = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

   logic [SAMPLE_BITS-1:0] center_ff;
   logic [SAMPLE_BITS-1:0] min_ff;
   logic [SAMPLE_BITS-1:0] max_ff;
   logic [SAMPLE_BITS-1:0] cur_center;
   logic [SAMPLE_BITS-1:0] cur_min;
   logic [SAMPLE_BITS-1:0] cur_max;
   logic [SUM_W-1:0]       cen_ext;
   logic [SUM_W-1:0]       smp_ext;
   logic [SUM_W-1:0]       wsum;
   logic [PROD_W-1:0]      prod;
   logic [SUM_W-1:0]       quot_est;
   logic [SUM_W-1:0]       rem;
   logic [SUM_W-1:0]       quot;

   // A restart request works from the reset values.
   assign cur_center = ctl.restart ? MID : center_ff;
   assign cur_min    = ctl.restart ? MID : min_ff;
   assign cur_max    = ctl.restart ? MID : max_ff;

   // Weighted sum 7*center + 3*sample, then floor division by ten.
   always_comb begin
      cen_ext  = SUM_W'(cur_center);
      smp_ext  = SUM_W'(sample);
      wsum     = (cen_ext << 3) - cen_ext + (smp_ext << 1) + smp_ext;
      prod     = PROD_W'(wsum) * PROD_W'(RECIP);
      quot_est = SUM_W'(prod >> SHIFT);
      rem      = wsum - (quot_est << 3) - (quot_est << 1);
      quot     = (rem >= TEN) ? (quot_est + SUM_W'(1)) : quot_est;
   end

   // Next state values for this request.
   always_comb begin
      center_in = cur_center;
      min_in    = cur_min;
      max_in    = cur_max;
      if (ctl.avg) begin
         center_in = quot[SAMPLE_BITS-1:0];
      end
      if (ctl.track) begin
         if (sample < cur_center) begin
            if (sample < cur_min) begin
               min_in = sample;
            end
         end else if (sample > cur_max) begin
            max_in = sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= MID;
         min_ff    <= MID;
         max_ff    <= MID;
      end else if (ctl.load) begin
         center_ff <= center_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/jccal_core.sv -----
// ----------------------------------------------------------------------------
// Joystick calibrator core
// Input register, phase sequencer, two axis datapaths and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jccal_core #(
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire jccal_pkg::cfg_type       cfg,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [SAMPLE_BITS-1:0]   in_sample_x,
   input  wire logic [SAMPLE_BITS-1:0]   in_sample_y,
   input  wire logic                     in_abort,
   input  wire logic                     in_restart,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output jccal_pkg::phase_type          out_phase,
   output logic      [SAMPLE_BITS-1:0]   out_center_x,
   output logic      [SAMPLE_BITS-1:0]   out_center_y,
   output logic      [SAMPLE_BITS-1:0]   out_min_x,
   output logic      [SAMPLE_BITS-1:0]   out_max_x,
   output logic      [SAMPLE_BITS-1:0]   out_min_y,
   output logic      [SAMPLE_BITS-1:0]   out_max_y,
   output logic                          out_finished
);

   localparam int TW = jccal_pkg::TICK_W;

   // Input register.
   logic                   s1_valid_ff;
   logic [SAMPLE_BITS-1:0] s1_x_ff;
   logic [SAMPLE_BITS-1:0] s1_y_ff;
   logic                   s1_abort_ff;
   logic                   s1_restart_ff;

   // Sequencer state.
   jccal_pkg::phase_type   phase_ff;
   jccal_pkg::phase_type   phase_in;
   logic [TW-1:0]          tick_ff;
   logic [TW-1:0]          tick_in;

   // Result register.
   logic                   rsp_valid_ff;
   jccal_pkg::phase_type   rsp_phase_ff;
   logic [SAMPLE_BITS-1:0] rsp_cx_ff;
   logic [SAMPLE_BITS-1:0] rsp_cy_ff;
   logic [SAMPLE_BITS-1:0] rsp_minx_ff;
   logic [SAMPLE_BITS-1:0] rsp_maxx_ff;
   logic [SAMPLE_BITS-1:0] rsp_miny_ff;
   logic [SAMPLE_BITS-1:0] rsp_maxy_ff;
   logic                   rsp_fin_ff;

   logic                   fire;
   jccal_pkg::phase_type   cur_phase;
   logic [TW-1:0]          cur_tick;
   logic [jccal_pkg::CFG_W-1:0] win_len;
   logic [TW-1:0]          win_end;
   jccal_pkg::window_type  win;
   jccal_pkg::axis_ctl_type ctl;
   logic                   finished;
   logic [SAMPLE_BITS-1:0] cx_in;
   logic [SAMPLE_BITS-1:0] cy_in;
   logic [SAMPLE_BITS-1:0] minx_in;
   logic [SAMPLE_BITS-1:0] maxx_in;
   logic [SAMPLE_BITS-1:0] miny_in;
   logic [SAMPLE_BITS-1:0] maxy_in;

   // The held request is processed when the result register can take it.
   assign fire     = s1_valid_ff && (!rsp_valid_ff || out_ready);
   assign in_ready = !s1_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_x_ff       <= in_sample_x;
         s1_y_ff       <= in_sample_y;
         s1_abort_ff   <= in_abort;
         s1_restart_ff <= in_restart;
      end
   end

   // A restart request starts from the reset state.
   assign cur_phase = s1_restart_ff ? jccal_pkg::PH_START : phase_ff;
   assign cur_tick  = s1_restart_ff ? '0 : tick_ff;

   // Pause, sampling and done windows of the center and sweep phases.
   always_comb begin
      win_len = (cur_phase == jccal_pkg::PH_CENTER) ? cfg.center_ticks : cfg.sweep_ticks;
      win_end = TW'(cfg.pause_ticks) + TW'(win_len);
      if (cur_tick == '0) begin
         win = jccal_pkg::WIN_COUNT;
      end else if (cur_tick > win_end) begin
         win = jccal_pkg::WIN_DONE;
      end else if (cur_tick > TW'(cfg.pause_ticks)) begin
         win = jccal_pkg::WIN_SAMPLE;
      end else begin
         win = jccal_pkg::WIN_COUNT;
      end
   end

   // Next phase and tick count.
   always_comb begin
      phase_in = cur_phase;
      tick_in  = cur_tick;
      unique case (cur_phase)
         jccal_pkg::PH_START: begin
            phase_in = jccal_pkg::PH_CENTER;
         end
         jccal_pkg::PH_CENTER: begin
            if (win == jccal_pkg::WIN_DONE) begin
               phase_in = jccal_pkg::PH_SWEEP;
               tick_in  = '0;
            end else begin
               tick_in = cur_tick + TW'(1);
            end
         end
         jccal_pkg::PH_SWEEP: begin
            if (win == jccal_pkg::WIN_DONE) begin
               phase_in = jccal_pkg::PH_READY;
            end else begin
               tick_in = cur_tick + TW'(1);
            end
         end
         jccal_pkg::PH_READY: begin
            phase_in = jccal_pkg::PH_IDLE;
         end
         default: begin
            phase_in = cur_phase;
         end
      endcase
      if (s1_abort_ff) begin
         phase_in = jccal_pkg::PH_EXIT;
      end
   end

   // Sequencer outputs: datapath controls and the finished flag.
   always_comb begin
      ctl.load    = fire;
      ctl.restart = s1_restart_ff;
      ctl.avg     = 1'b0;
      ctl.track   = 1'b0;
      unique case (cur_phase)
         jccal_pkg::PH_CENTER: ctl.avg   = (win == jccal_pkg::WIN_SAMPLE);
         jccal_pkg::PH_SWEEP:  ctl.track = (win == jccal_pkg::WIN_SAMPLE);
         default:              ctl.avg   = 1'b0;
      endcase
      finished = (phase_in == jccal_pkg::PH_READY) || (phase_in == jccal_pkg::PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jccal_pkg::PH_START;
         tick_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
      end
   end

   jccal_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sample    (s1_x_ff),
      .center_in (cx_in),
      .min_in    (minx_in),
      .max_in    (maxx_in)
   );

   jccal_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_y (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sample    (s1_y_ff),
      .center_in (cy_in),
      .min_in    (miny_in),
      .max_in    (maxy_in)
   );

   // Result register: holds a finished result while the next request is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_phase_ff <= phase_in;
         rsp_cx_ff    <= cx_in;
         rsp_cy_ff    <= cy_in;
         rsp_minx_ff  <= minx_in;
         rsp_maxx_ff  <= maxx_in;
         rsp_miny_ff  <= miny_in;
         rsp_maxy_ff  <= maxy_in;
         rsp_fin_ff   <= finished;
      end
   end

   assign out_valid    = rsp_valid_ff;
   assign out_phase    = rsp_phase_ff;
   assign out_center_x = rsp_cx_ff;
   assign out_center_y = rsp_cy_ff;
   assign out_min_x    = rsp_minx_ff;
   assign out_max_x    = rsp_maxx_ff;
   assign out_min_y    = rsp_miny_ff;
   assign out_max_y    = rsp_maxy_ff;
   assign out_finished = rsp_fin_ff;

endmodule

`default_nettype wire

// ----- rtl/jccal_checker.sv -----
// ----------------------------------------------------------------------------
// Joystick calibrator checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module jccal_checker #(
   parameter int SAMPLE_BITS = 12
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [((3+6*SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   input wire logic [0:0]                          rsp_tuser
);

   localparam int SB = SAMPLE_BITS;

   logic [2:0]    phase;
   logic [SB-1:0] min_x;
   logic [SB-1:0] max_x;
   logic [SB-1:0] min_y;
   logic [SB-1:0] max_y;
   logic          fin_expect;

   assign phase = rsp_tdata[2:0];
   assign min_x = rsp_tdata[3+2*SB +: SB];
   assign max_x = rsp_tdata[3+3*SB +: SB];
   assign min_y = rsp_tdata[3+4*SB +: SB];
   assign max_y = rsp_tdata[3+5*SB +: SB];
   assign fin_expect = (phase == jccal_pkg::PH_READY) || (phase == jccal_pkg::PH_IDLE);

   // A stalled response keeps its contents.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // No response is left over from before reset.
   `ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_tvalid)

   // The finished flag agrees with the reported phase.
   `ASSERT_CLK(a_fin_phase, clock, reset, rsp_tvalid |-> rsp_tuser[0] == fin_expect)

   // The range only widens from the midpoint, so min never passes max.
   `ASSERT_CLK(a_range_order, clock, reset, rsp_tvalid |-> (min_x <= max_x) && (min_y <= max_y))

endmodule

bind joystick_center_range_calibrator_unit jccal_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
